// ===== src/line_buffered_rx_fifo_macros.svh =====
// Assertion macros shared by the verification files of the line-buffered receive FIFO.
// Depends on nothing; the including module must provide aclk and aresetn.
`ifndef LINE_BUFFERED_RX_FIFO_MACROS_SVH
`define LINE_BUFFERED_RX_FIFO_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LBRX_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LBRX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lbrx_pkg.sv =====
// Shared types and constants for the line-buffered receive FIFO.
// Used by the front end, the back end, the top level and the checker.
package lbrx_pkg;

    // Ring size and pointer width.
    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);

    localparam logic [7:0] NL_BYTE = 8'h0A;

    // Input opcodes.
    localparam logic [1:0] OPC_PUSH = 2'd0;
    localparam logic [1:0] OPC_ALL  = 2'd1;
    localparam logic [1:0] OPC_LINE = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    // Command classes passed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_ALL,
        CMD_LINE,
        CMD_NONE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
    } cmd_t;

    // Ring pointer increment with wrap.
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== src/line_buffered_rx_fifo.sv =====
// Top level of the line-buffered receive FIFO.
// Depends on lbrx_pkg, lbrx_front and lbrx_back.
//
//   Channel  Direction  Handshake          Word
//   s_       in         s_valid/s_ready    s_opcode, s_rx_byte
//   m_       out        m_valid/m_ready    m_kind, m_out_byte, m_last, m_overrun
//
// A drain primes the ring's read port first, then sends one byte a cycle from the
// single read port of the 64-byte ring while the output is not stalled.
// The front end takes a word every cycle while its two-entry queue has room.
// Reset is synchronous and active low; the ring contents are not cleared.
// A stall on m_ready holds the output register and the back end in place.
module line_buffered_rx_fifo (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_out_byte,
    output logic       m_last,
    output logic       m_overrun
);

    logic           q_valid;
    lbrx_pkg::cmd_t q_cmd;
    logic           q_pop;

    // Decode and queue incoming words.
    lbrx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_rx_byte (s_rx_byte),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    // Execute commands against the ring.
    lbrx_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .m_overrun  (m_overrun)
    );

endmodule

// ===== src/lbrx_front.sv =====
// Front end of the line-buffered receive FIFO: decodes input words into commands
// and holds them in a two-entry queue. Depends on lbrx_pkg.
module lbrx_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [7:0]        s_rx_byte,
    output logic              q_valid,
    output lbrx_pkg::cmd_t    q_cmd,
    input  logic              q_pop
);

    lbrx_pkg::cmd_t q_mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    lbrx_pkg::cmd_t dec_cmd;
    logic           push_en;

    // Classify the opcode; the unused code becomes a command that only reports.
    always_comb begin
        dec_cmd.data = s_rx_byte;
        case (s_opcode)
            lbrx_pkg::OPC_PUSH: dec_cmd.op = lbrx_pkg::CMD_PUSH;
            lbrx_pkg::OPC_ALL:  dec_cmd.op = lbrx_pkg::CMD_ALL;
            lbrx_pkg::OPC_LINE: dec_cmd.op = lbrx_pkg::CMD_LINE;
            default:            dec_cmd.op = lbrx_pkg::CMD_NONE;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push_en = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = q_mem_reg[rd_ptr_reg];

    // Queue pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push_en && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push_en && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push_en) begin
            q_mem_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

// ===== src/lbrx_back.sv =====
// Back end of the line-buffered receive FIFO: byte ring, pointers, newline mark
// and the drain sequencer with the output register. Depends on lbrx_pkg.
module lbrx_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  lbrx_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [7:0]        m_out_byte,
    output logic              m_last,
    output logic              m_overrun
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    localparam int PW = lbrx_pkg::PTR_W;

    state_t          state_reg, state_next;
    logic [PW-1:0]   head_reg, head_next;
    logic [PW-1:0]   tail_reg, tail_next;
    logic [PW-1:0]   cur_reg, cur_next;
    logic [PW-1:0]   cnt_reg, cnt_next;
    logic            nl_valid_reg, nl_valid_next;
    logic [PW-1:0]   nl_pos_reg, nl_pos_next;
    logic            line_mode_reg, line_mode_next;
    logic            m_valid_reg, m_valid_next;
    logic [1:0]      m_kind_reg, m_kind_next;
    logic [7:0]      m_byte_reg, m_byte_next;
    logic            m_last_reg, m_last_next;
    logic            m_ovr_reg, m_ovr_next;

    logic [7:0]      mem [lbrx_pkg::DEPTH];
    logic [7:0]      rd_data_reg;
    logic            mem_we;
    logic            mem_re;
    logic [PW-1:0]   mem_raddr;
    logic            out_free;
    logic            not_empty;
    logic            drain_done;
    logic [PW-1:0]   head_inc;
    logic [PW-1:0]   cur_inc;

    assign out_free  = !m_valid_reg || m_ready;
    assign not_empty = (head_reg != tail_reg);
    assign head_inc  = lbrx_pkg::next_ptr(head_reg);
    assign cur_inc   = lbrx_pkg::next_ptr(cur_reg);

    // The word in hand is the last of a drain when the walk reaches its stop.
    always_comb begin
        if (line_mode_reg) begin
            drain_done = (cur_reg == nl_pos_reg) || (rd_data_reg == lbrx_pkg::NL_BYTE)
                      || (cnt_reg == PW'(lbrx_pkg::DEPTH - 1));
        end else begin
            drain_done = (cur_inc == head_reg);
        end
    end

    // Command execution and drain sequencing.
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        nl_valid_next  = nl_valid_reg;
        nl_pos_next    = nl_pos_reg;
        line_mode_next = line_mode_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_kind_next    = m_kind_reg;
        m_byte_next    = m_byte_reg;
        m_last_next    = m_last_reg;
        m_ovr_next     = m_ovr_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = cur_reg;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    // Default outcome is the nothing-to-read report.
                    m_valid_next = 1'b1;
                    m_kind_next  = lbrx_pkg::KIND_NONE;
                    m_byte_next  = 8'h00;
                    m_last_next  = 1'b1;
                    m_ovr_next   = 1'b0;
                    case (q_cmd.op)
                        lbrx_pkg::CMD_PUSH: begin
                            mem_we    = 1'b1;
                            head_next = head_inc;
                            if (q_cmd.data == lbrx_pkg::NL_BYTE) begin
                                nl_valid_next = 1'b1;
                                nl_pos_next   = head_reg;
                            end
                            m_kind_next = lbrx_pkg::KIND_ACK;
                            m_ovr_next  = (head_inc == tail_reg);
                        end
                        lbrx_pkg::CMD_ALL, lbrx_pkg::CMD_LINE: begin
                            if (not_empty && (q_cmd.op == lbrx_pkg::CMD_ALL || nl_valid_reg))
                            begin
                                m_valid_next   = 1'b0;
                                mem_re         = 1'b1;
                                mem_raddr      = tail_reg;
                                cur_next       = tail_reg;
                                cnt_next       = '0;
                                line_mode_next = (q_cmd.op == lbrx_pkg::CMD_LINE);
                                state_next     = ST_DRAIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = lbrx_pkg::KIND_DATA;
                    m_byte_next  = rd_data_reg;
                    m_last_next  = drain_done;
                    m_ovr_next   = 1'b0;
                    if (drain_done) begin
                        tail_next  = cur_inc;
                        state_next = ST_IDLE;
                        if (!line_mode_reg || cur_reg == nl_pos_reg) begin
                            nl_valid_next = 1'b0;
                        end
                    end else begin
                        cur_next  = cur_inc;
                        cnt_next  = cnt_reg + PW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = cur_inc;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, pointers and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            nl_valid_reg <= 1'b0;
            nl_pos_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nl_valid_reg <= nl_valid_next;
            nl_pos_reg   <= nl_pos_next;
            m_valid_reg  <= m_valid_next;
        end
        cur_reg       <= cur_next;
        cnt_reg       <= cnt_next;
        line_mode_reg <= line_mode_next;
        m_kind_reg    <= m_kind_next;
        m_byte_reg    <= m_byte_next;
        m_last_reg    <= m_last_next;
        m_ovr_reg     <= m_ovr_next;
    end

    // Byte ring: one write port at the head, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[head_reg] <= q_cmd.data;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;
    assign m_overrun  = m_ovr_reg;

endmodule

// ===== src/lbrx_checker.sv =====
// Port-level checker for the line-buffered receive FIFO, bound to the top level.
// Depends on lbrx_pkg and line_buffered_rx_fifo_macros.svh.
`include "line_buffered_rx_fifo_macros.svh"

module lbrx_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_opcode,
    input logic [7:0] s_rx_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [7:0] m_out_byte,
    input logic       m_last,
    input logic       m_overrun
);

    // A waiting input word holds until it is taken.
    `LBRX_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_opcode) && $stable(s_rx_byte), "input word changed while waiting")

    // A stalled result word holds.
    `LBRX_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_out_byte) && $stable(m_last) && $stable(m_overrun), "result word changed while stalled")

    // A nothing-to-read report is a single, empty, final word.
    `LBRX_ASSERT(a_none, m_valid && m_kind == lbrx_pkg::KIND_NONE, m_last && m_out_byte == 8'h00 && !m_overrun, "malformed empty report")

    // A push acknowledgement is always final and carries no byte.
    `LBRX_ASSERT(a_ack, m_valid && m_kind == lbrx_pkg::KIND_ACK, m_last && m_out_byte == 8'h00, "malformed push acknowledgement")

    // Overrun is flagged only on push acknowledgements.
    `LBRX_ASSERT(a_ovr, m_valid && m_overrun, m_kind == lbrx_pkg::KIND_ACK, "overrun on a non-push word")

endmodule

bind line_buffered_rx_fifo lbrx_checker u_lbrx_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the line-buffered receive FIFO.
// Depends on lbrx_pkg and line_buffered_rx_fifo; a directed script runs first, then random traffic.
`timescale 1ns / 1ps

module tb_top;
    import lbrx_pkg::*;

    // The spare opcode has no name in the package; the block answers it as nothing to read.
    localparam logic [1:0] OPC_SPARE = 2'd3;
    localparam int RUN_LIMIT = 400000;
    localparam int TARGET_ITEMS = 230;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       ovr;
    } word_t;

    typedef struct {
        logic [1:0] op;
        logic [7:0] b;
        bit         typed;
        word_t      want;
    } script_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_opcode = OPC_PUSH;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_out_byte;
    logic       m_last;
    logic       m_overrun;

    // Shadow copy of the ring and its pointers.
    logic [7:0]       ring_mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr = '0;
    logic [PTR_W-1:0] rd_ptr = '0;
    logic             nl_mark = 1'b0;
    logic [PTR_W-1:0] nl_at = '0;

    word_t       due_words [$];
    script_row_t script [$];
    int          errors = 0;
    int          taken = 0;
    int          counted = 0;
    int          cycles = 0;
    bit          calm_tx = 1'b0;
    word_t       seen;

    line_buffered_rx_fifo dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_out_byte(m_out_byte),
        .m_last    (m_last),
        .m_overrun (m_overrun)
    );

    // Free-running clock, 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic word_t make_word(input logic [1:0] kind, input logic [7:0] data,
                                        input logic last, input logic ovr);
        word_t w;
        w.kind = kind;
        w.data = data;
        w.last = last;
        w.ovr  = ovr;
        return w;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == NL_BYTE) begin
            b = 8'h20;
        end
        return b;
    endfunction

    // Works out the words that one accepted command produces and updates the shadow ring.
    task automatic forecast_ring(input logic [1:0] op, input logic [7:0] b);
        logic [PTR_W-1:0] i;
        int               n;
        n = 0;
        if (op == OPC_PUSH) begin
            ring_mem[wr_ptr] = b;
            if (b == NL_BYTE) begin
                nl_at   = wr_ptr;
                nl_mark = 1'b1;
            end
            wr_ptr = PTR_W'(wr_ptr + 1'b1);
            due_words.push_back(make_word(KIND_ACK, 8'h00, 1'b1, wr_ptr == rd_ptr));
        end else if (op == OPC_ALL && wr_ptr != rd_ptr) begin
            // Everything from the tail up to the head goes out, and the mark is dropped.
            for (i = rd_ptr; i != wr_ptr; i = PTR_W'(i + 1'b1)) begin
                due_words.push_back(make_word(KIND_DATA, ring_mem[i],
                                              PTR_W'(i + 1'b1) == wr_ptr, 1'b0));
            end
            rd_ptr  = wr_ptr;
            nl_mark = 1'b0;
        end else if (op == OPC_LINE && wr_ptr != rd_ptr && nl_mark) begin
            // Walk from the tail to the first newline, the marked slot or the length cap, whichever comes first.
            i = rd_ptr;
            while (i != nl_at && n < DEPTH - 1) begin
                if (ring_mem[i] == NL_BYTE) begin
                    break;
                end
                due_words.push_back(make_word(KIND_DATA, ring_mem[i], 1'b0, 1'b0));
                n++;
                i = PTR_W'(i + 1'b1);
            end
            due_words.push_back(make_word(KIND_DATA, ring_mem[i], 1'b1, 1'b0));
            n++;
            rd_ptr = PTR_W'(rd_ptr + PTR_W'(n));
            if (i == nl_at) begin
                nl_mark = 1'b0;
            end
        end else begin
            due_words.push_back(make_word(KIND_NONE, 8'h00, 1'b1, 1'b0));
        end
    endtask

    // Presents one command and waits for the handshake; a typed row replaces the forecast.
    task automatic offer_cmd(input logic [1:0] op, input logic [7:0] b,
                             input bit typed, input word_t want);
        int gap;
        int base;
        gap = calm_tx ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        base = due_words.size();
        forecast_ring(op, b);
        if (typed) begin
            while (due_words.size() > base) begin
                void'(due_words.pop_back());
            end
            due_words.push_back(want);
        end
        counted++;
    endtask

    task automatic offer_plain(input logic [1:0] op, input logic [7:0] b);
        offer_cmd(op, b, 1'b0, '0);
    endtask

    // Holds the sender off until every expected word has come back.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_words.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic void add_row(input logic [1:0] op, input logic [7:0] b, input bit typed,
                                    input logic [1:0] kind, input logic ovr);
        script_row_t r;
        r.op    = op;
        r.b     = b;
        r.typed = typed;
        r.want  = make_word(kind, 8'h00, 1'b1, ovr);
        script.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch on word %0d, %s: got %0h, expected %0h", taken, what, got, want);
    endtask

    // Result side: accepted words are compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_words.size() == 0) begin
                report_mismatch("word with nothing expected", m_kind, 0);
            end else begin
                seen = due_words.pop_front();
                if (m_kind !== seen.kind) report_mismatch("kind", m_kind, seen.kind);
                if (m_out_byte !== seen.data) report_mismatch("out_byte", m_out_byte, seen.data);
                if (m_last !== seen.last) report_mismatch("last", m_last, seen.last);
                if (m_overrun !== seen.ovr) report_mismatch("overrun", m_overrun, seen.ovr);
            end
            taken++;
        end
    end

    // Receiver back-pressure, with calm stretches where it never stalls.
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = ((taken / 32) % 3 == 2) ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycles < RUN_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_top: errors");
        $finish;
    end

    // Stimulus: reset, directed script, random traffic, then drain and verdict.
    initial begin
        int pick;
        int len;
        int nl_spot;

        // Directed script: empty ring, spare opcode, byte extremes, lines and mark handling.
        add_row(OPC_ALL,   8'h00,   1'b1, KIND_NONE, 1'b0);
        add_row(OPC_LINE,  8'hFF,   1'b1, KIND_NONE, 1'b0);
        add_row(OPC_SPARE, 8'h00,   1'b1, KIND_NONE, 1'b0);
        add_row(OPC_PUSH,  8'h00,   1'b1, KIND_ACK,  1'b0);
        add_row(OPC_PUSH,  8'hFF,   1'b1, KIND_ACK,  1'b0);
        add_row(OPC_PUSH,  8'h41,   1'b0, KIND_ACK,  1'b0);
        add_row(OPC_LINE,  8'h00,   1'b1, KIND_NONE, 1'b0);
        add_row(OPC_PUSH,  NL_BYTE, 1'b1, KIND_ACK,  1'b0);
        add_row(OPC_PUSH,  8'h42,   1'b0, KIND_ACK,  1'b0);
        add_row(OPC_PUSH,  NL_BYTE, 1'b0, KIND_ACK,  1'b0);
        add_row(OPC_PUSH,  8'h43,   1'b0, KIND_ACK,  1'b0);
        // Stops at the earlier newline, so the mark survives.
        add_row(OPC_LINE,  8'h00,   1'b0, KIND_NONE, 1'b0);
        // Reaches the marked newline and clears the mark.
        add_row(OPC_LINE,  8'hAA,   1'b0, KIND_NONE, 1'b0);
        add_row(OPC_LINE,  8'h00,   1'b1, KIND_NONE, 1'b0);
        add_row(OPC_ALL,   8'h55,   1'b0, KIND_NONE, 1'b0);
        add_row(OPC_ALL,   8'h00,   1'b1, KIND_NONE, 1'b0);
        add_row(OPC_SPARE, 8'hFF,   1'b1, KIND_NONE, 1'b0);
        add_row(OPC_PUSH,  8'h80,   1'b0, KIND_ACK,  1'b0);
        add_row(OPC_PUSH,  8'h7F,   1'b0, KIND_ACK,  1'b0);
        add_row(OPC_ALL,   8'h00,   1'b0, KIND_NONE, 1'b0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[k]) begin
            offer_cmd(script[k].op, script[k].b, script[k].typed, script[k].want);
        end
        settle();

        // Random traffic: mostly whole lines, with drains, noise and overrun bursts.
        pick = 8;
        while (counted < TARGET_ITEMS) begin
            calm_tx = ($urandom_range(0, 4) == 0);
            case (pick)
                0, 1, 2, 3, 4: begin
                    len = $urandom_range(0, 8);
                    repeat (len) offer_plain(OPC_PUSH, 8'($urandom_range(0, 255)));
                    offer_plain(OPC_PUSH, NL_BYTE);
                    if ($urandom_range(0, 1) == 1) begin
                        offer_plain(OPC_LINE, 8'($urandom_range(0, 255)));
                    end
                end
                5, 6: begin
                    offer_plain(OPC_LINE, 8'($urandom_range(0, 255)));
                end
                7: begin
                    offer_plain(OPC_ALL, 8'($urandom_range(0, 255)));
                end
                8: begin
                    // Fill a whole lap so the head meets the tail, then walk the stale mark.
                    settle();
                    offer_plain(OPC_ALL, 8'h00);
                    nl_spot = $urandom_range(0, 10);
                    for (int k = 0; k < DEPTH; k++) begin
                        offer_plain(OPC_PUSH, (k == nl_spot) ? NL_BYTE : text_byte());
                    end
                    len = $urandom_range(1, 5);
                    repeat (len) offer_plain(OPC_PUSH, text_byte());
                    offer_plain(OPC_LINE, 8'h00);
                    offer_plain(OPC_ALL, 8'h00);
                end
                9, 10: begin
                    offer_plain(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
                default: begin
                    settle();
                end
            endcase
            pick = $urandom_range(0, 14);
            if (pick > 11) begin
                pick = $urandom_range(0, 4);
            end
        end

        settle();
        repeat (80) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
